@@ hdl/qerm_pkg.sv @@
// Shared types, constants and decode function for the quadrature encoder speed meter.
package qerm_pkg;

   // Field widths fixed by the item layout.
   localparam int SPEED_W = 16;
   localparam int COUNT_W = 16;
   localparam int PINS_W  = 2;
   localparam int DIR_W   = 2;

   // Default history depth and register reset value.
   localparam int                 DEF_HISTORY_DEPTH = 5;
   localparam logic [SPEED_W-1:0] RPM_SCALE_RESET   = 16'd15000;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

   // Item kinds.
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_ENC  = 1'b1;

   // Direction codes.
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

   typedef struct packed {
      logic              func;
      logic [PINS_W-1:0] pins;
   } req_type;

   typedef struct packed {
      logic [DIR_W-1:0]   direction;
      logic [SPEED_W-1:0] speed;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic tick;
      logic enc;
      logic hold_rsp;
      logic sum_step;
      logic div_start;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic moving;
      logic sum_last;
      logic div_done;
   } status_type;

   // Decode the previous and current pin pair into a direction.
   function automatic logic [DIR_W-1:0] classify(input logic [2*PINS_W-1:0] code);
      logic [DIR_W-1:0] dir;
      case (code) inside
         4'd1, 4'd7, 4'd8, 4'd14:  dir = DIR_CW;
         4'd2, 4'd4, 4'd11, 4'd13: dir = DIR_CCW;
         default:                  dir = DIR_NONE;
      endcase
      return dir;
   endfunction

endpackage

@@ hdl/qerm_div.sv @@
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module qerm_div #(
   parameter int DW = qerm_pkg::SPEED_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [DW-1:0] quo
);

   localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DW:0]      shifted;
   logic [DW:0]      diff;

   // One restoring step: shift in the next numerator bit and try to subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, den_ff};
      if (!diff[DW]) begin
         rem_in = diff[DW-1:0];
         quo_in = {quo_ff[DW-2:0], 1'b1};
      end else begin
         rem_in = shifted[DW-1:0];
         quo_in = {quo_ff[DW-2:0], 1'b0};
      end
   end

   // Control of the iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Remainder, quotient and divisor registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ hdl/qerm_dp.sv @@
// Datapath: pin decode, interval counter, history, mean and speed arithmetic.
module qerm_dp #(
   parameter int HISTORY_DEPTH = qerm_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qerm_pkg::cmd_type             cmd,
   output qerm_pkg::status_type          status,
   input  qerm_pkg::req_type             req_data,
   output qerm_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [qerm_pkg::SPEED_W-1:0]  csr_wdata
);

   localparam int SUM_W = qerm_pkg::COUNT_W + $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SPD_W = qerm_pkg::SPEED_W;

   // The mean divides by the element count, a constant. A rounded-up reciprocal
   // scaled by 2**RECIP_SH makes (sum * RECIP) >> RECIP_SH the exact truncated
   // quotient for every sum that fits in SUM_W bits.
   localparam int DIVISOR  = HISTORY_DEPTH + 1;
   localparam int RECIP_SH = SUM_W + $clog2(DIVISOR);
   localparam int RECIP_W  = SUM_W + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << RECIP_SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

   logic [qerm_pkg::SPEED_W-1:0] scale_ff;
   logic [qerm_pkg::PINS_W-1:0]  prev_pins_ff;
   logic [qerm_pkg::COUNT_W-1:0] count_ff;
   logic [qerm_pkg::COUNT_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [qerm_pkg::SPEED_W-1:0] speed_ff;
   logic [qerm_pkg::DIR_W-1:0]   dir_ff;
   logic [SUM_W-1:0]             acc_ff;
   logic [IDX_W-1:0]             idx_ff;
   qerm_pkg::rsp_type            rsp_ff;

   logic [qerm_pkg::DIR_W-1:0]   dir_now;
   logic [PROD_W-1:0]            mean_prod;
   logic [qerm_pkg::SPEED_W-1:0] mean;
   logic [qerm_pkg::SPEED_W-1:0] div_den;
   logic [qerm_pkg::SPEED_W-1:0] div_quo;
   logic                         div_done;
   logic [qerm_pkg::SPEED_W-1:0] speed_new;

   // Decode the pin pair of the current beat against the stored pair.
   assign dir_now = qerm_pkg::classify({prev_pins_ff, req_data.pins});

   // Mean of the intervals by reciprocal multiply; a zero mean counts as one.
   assign mean_prod = PROD_W'(acc_ff) * PROD_W'(RECIP);
   assign mean      = mean_prod[RECIP_SH +: qerm_pkg::SPEED_W];
   assign div_den   = (mean == '0) ? SPD_W'(1) : mean;

   // The divider turns scale over mean into the speed.
   qerm_div #(
      .DW (qerm_pkg::SPEED_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (scale_ff),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign speed_new = div_quo;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= qerm_pkg::RPM_SCALE_RESET;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
   end

   // Pin history, interval counter, interval history and speed.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff <= '0;
         count_ff     <= '0;
         speed_ff     <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         if (cmd.tick && count_ff != qerm_pkg::COUNT_MAX) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.enc) begin
            prev_pins_ff <= req_data.pins;
         end
         if (cmd.commit) begin
            speed_ff   <= speed_new;
            count_ff   <= '0;
            hist_ff[0] <= count_ff;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
      end
   end

   // Running sum over the current interval and the stored intervals.
   always_ff @(posedge clock) begin
      if (cmd.enc) begin
         dir_ff <= dir_now;
         acc_ff <= SUM_W'(count_ff);
         idx_ff <= '0;
      end else if (cmd.sum_step) begin
         acc_ff <= acc_ff + SUM_W'(hist_ff[idx_ff]);
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.hold_rsp) begin
         rsp_ff.direction <= qerm_pkg::DIR_NONE;
         rsp_ff.speed     <= speed_ff;
      end else if (cmd.commit) begin
         rsp_ff.direction <= dir_ff;
         rsp_ff.speed     <= speed_new;
      end
   end

   assign status.moving   = (dir_now != qerm_pkg::DIR_NONE);
   assign status.sum_last = (idx_ff == IDX_W'(HISTORY_DEPTH - 1));
   assign status.div_done = div_done;
   assign rsp_data        = rsp_ff;

endmodule

@@ hdl/qerm_ctrl.sv @@
// Controller: sequences accept, summation, the speed division and result hand-off.
module qerm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output qerm_pkg::cmd_type    cmd,
   input  qerm_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SPEED_GO,
      ST_SPEED,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new beat at this edge.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = (req_func == qerm_pkg::FUNC_ENC) && !out_free;
            if (req_valid && !req_stall) begin
               if (req_func == qerm_pkg::FUNC_TICK) begin
                  cmd.tick = 1'b1;
               end else begin
                  cmd.enc = 1'b1;
                  if (status.moving) begin
                     state_in = ST_SUM;
                  end else begin
                     cmd.hold_rsp = 1'b1;
                  end
               end
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) begin
               state_in = ST_SPEED_GO;
            end
         end
         ST_SPEED_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_SPEED;
         end
         ST_SPEED: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on a load, cleared when the beat is taken.
   always_comb begin
      if (cmd.hold_rsp || cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/quadrature_encoder_rpm_meter.sv @@
// Top level of the quadrature encoder decoder with speed meter.
//
// The req channel carries two kinds of beats: a timer tick (func 0) that advances
// the saturating interval counter, and an encoder sample (func 1) with the A/B pin
// levels. Only encoder samples produce a beat on the rsp channel, giving the
// direction and the current speed. The csr port writes the speed scale numerator.
// An encoder sample with no valid step loads its answer into the result register as
// it is accepted. A valid step sums the current and stored intervals, forms the mean
// by a reciprocal multiply as the bit-serial divider starts, and divides the scale by
// the mean at one quotient bit per cycle.
// One item is in work at a time; the next may be accepted while the result waits.
// Reset clears the counter, history, pin pair and speed and loads the default scale.
// A stalled result holds its beat; an encoder sample is then held off until the
// result register frees up, while ticks are still taken.
module quadrature_encoder_rpm_meter #(
   parameter int HISTORY_DEPTH = qerm_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  qerm_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output qerm_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [qerm_pkg::SPEED_W-1:0] csr_wdata
);

   qerm_pkg::cmd_type    cmd;
   qerm_pkg::status_type status;

   // Sequencer.
   qerm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and state.
   qerm_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the quadrature encoder speed meter: directed plan, then random.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST  = qerm_pkg::DEF_HISTORY_DEPTH;
   localparam int SPD_W = qerm_pkg::SPEED_W;
   localparam int PIN_W = qerm_pkg::PINS_W;
   // Settling wait after the last result, with margin over a valid step at the default depth.
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_REPORTS = 10;

   // Short names for the item kinds and direction codes used in the plan.
   localparam logic                         TICK = qerm_pkg::FUNC_TICK;
   localparam logic                         ENC  = qerm_pkg::FUNC_ENC;
   localparam logic [qerm_pkg::DIR_W-1:0]   NONE = qerm_pkg::DIR_NONE;
   localparam logic [qerm_pkg::DIR_W-1:0]   CW   = qerm_pkg::DIR_CW;
   localparam logic [qerm_pkg::DIR_W-1:0]   CCW  = qerm_pkg::DIR_CCW;

   logic                         clock;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   qerm_pkg::req_type            req_data  = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   qerm_pkg::rsp_type            rsp_data;
   logic                         csr_we    = 1'b0;
   logic [qerm_pkg::SPEED_W-1:0] csr_wdata = '0;

   // Shadow state of the meter, advanced on every accepted request beat.
   logic [qerm_pkg::SPEED_W-1:0] scale_shadow;
   logic [qerm_pkg::PINS_W-1:0]  last_pins;
   logic [qerm_pkg::COUNT_W-1:0] tick_span;
   logic [qerm_pkg::COUNT_W-1:0] span_hist [HIST];
   logic [qerm_pkg::SPEED_W-1:0] speed_est;

   // Results still owed by the block, oldest first.
   qerm_pkg::rsp_type speed_expect_q [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int beats_sent    = 0;
   int ticks_sent    = 0;
   int results_seen  = 0;
   int mismatches    = 0;

   // One row of the directed plan; typed-in results are pinned, others come from the shadow.
   typedef struct {
      logic                        func;
      logic [qerm_pkg::PINS_W-1:0] pins;
      int unsigned                 count;
      bit                          pinned;
      qerm_pkg::rsp_type           want;
   } plan_row_type;

   localparam logic [qerm_pkg::SPEED_W-1:0] SR = qerm_pkg::RPM_SCALE_RESET;

   plan_row_type plan [25] = '{
      '{ENC,  2'd0, 1,  1'b1, '{NONE, 16'd0}},      // no step, speed still clear
      '{ENC,  2'd1, 1,  1'b1, '{CW,   SR}},         // zero mean saturates
      '{ENC,  2'd3, 1,  1'b1, '{CW,   SR}},
      '{ENC,  2'd2, 1,  1'b1, '{CW,   SR}},
      '{ENC,  2'd0, 1,  1'b1, '{CW,   SR}},
      '{ENC,  2'd2, 1,  1'b1, '{CCW,  SR}},
      '{ENC,  2'd3, 1,  1'b1, '{CCW,  SR}},
      '{ENC,  2'd1, 1,  1'b1, '{CCW,  SR}},
      '{ENC,  2'd0, 1,  1'b1, '{CCW,  SR}},
      '{ENC,  2'd3, 1,  1'b1, '{NONE, SR}},         // both channels jump
      '{ENC,  2'd3, 1,  1'b1, '{NONE, SR}},
      '{ENC,  2'd0, 1,  1'b1, '{NONE, SR}},         // both channels jump
      '{ENC,  2'd1, 1,  1'b1, '{CW,   SR}},
      '{ENC,  2'd1, 1,  1'b1, '{NONE, SR}},
      '{ENC,  2'd2, 1,  1'b1, '{NONE, SR}},         // both channels jump
      '{ENC,  2'd2, 1,  1'b1, '{NONE, SR}},
      '{ENC,  2'd1, 1,  1'b1, '{NONE, SR}},         // both channels jump
      '{TICK, 2'd0, 12, 1'b0, '{NONE, 16'd0}},
      '{ENC,  2'd3, 1,  1'b1, '{CW,   16'd7500}},   // mean of 12 over six is 2
      '{TICK, 2'd3, 40, 1'b0, '{NONE, 16'd0}},      // a longer pause between edges
      '{ENC,  2'd2, 1,  1'b0, '{NONE, 16'd0}},
      '{TICK, 2'd0, 3,  1'b0, '{NONE, 16'd0}},
      '{ENC,  2'd1, 1,  1'b0, '{NONE, 16'd0}},      // jump keeps the count running
      '{TICK, 2'd0, 3,  1'b0, '{NONE, 16'd0}},
      '{ENC,  2'd0, 1,  1'b0, '{NONE, 16'd0}}
   };

   quadrature_encoder_rpm_meter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Next pin pair one step clockwise along the Gray sequence 0, 1, 3, 2.
   function automatic logic [qerm_pkg::PINS_W-1:0] cw_next(
         input logic [qerm_pkg::PINS_W-1:0] p);
      logic [qerm_pkg::PINS_W-1:0] n;
      case (p)
         2'd0:    n = 2'd1;
         2'd1:    n = 2'd3;
         2'd3:    n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   // Three clockwise steps make one counter-clockwise step.
   function automatic logic [qerm_pkg::PINS_W-1:0] ccw_next(
         input logic [qerm_pkg::PINS_W-1:0] p);
      return cw_next(cw_next(cw_next(p)));
   endfunction

   task automatic clear_meter_shadow();
      int i;
      scale_shadow = qerm_pkg::RPM_SCALE_RESET;
      last_pins    = '0;
      tick_span    = '0;
      speed_est    = '0;
      for (i = 0; i < HIST; i++) span_hist[i] = '0;
   endtask

   // Advance the shadow by one request beat; an encoder sample yields one result.
   function automatic void advance_meter(input qerm_pkg::req_type beat, output bit has_rsp,
                                         output qerm_pkg::rsp_type res);
      logic [qerm_pkg::DIR_W-1:0] dir;
      logic [31:0]                total;
      logic [31:0]                mean;
      int                         i;
      has_rsp = 1'b0;
      res     = '0;
      if (beat.func == TICK) begin
         if (tick_span != qerm_pkg::COUNT_MAX) tick_span = tick_span + 1'b1;
         return;
      end
      if (cw_next(last_pins) == beat.pins)
         dir = CW;
      else if (cw_next(beat.pins) == last_pins)
         dir = CCW;
      else
         dir = NONE;
      // A step takes the mean over the live interval and the stored ones, then shifts.
      if (dir != NONE) begin
         total = 32'(tick_span);
         for (i = 0; i < HIST; i++) total = total + 32'(span_hist[i]);
         mean = total / 32'(HIST + 1);
         if (mean == 0) mean = 1;
         speed_est = SPD_W'(32'(scale_shadow) / mean);
         for (i = HIST - 1; i > 0; i--) span_hist[i] = span_hist[i - 1];
         span_hist[0] = tick_span;
         tick_span    = '0;
      end
      last_pins     = beat.pins;
      has_rsp       = 1'b1;
      res.direction = dir;
      res.speed     = speed_est;
   endfunction

   function automatic void note_fault(input string what, input qerm_pkg::rsp_type want,
                                      input qerm_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t ERROR %s: expected dir %0d speed %0d, got dir %0d speed %0d",
                  $time, what, want.direction, want.speed, got.direction, got.speed);
   endfunction

   // Drive one request beat, wait for it to be taken, then update the shadow.
   task automatic send_beat(input qerm_pkg::req_type beat, input bit pinned = 1'b0,
                            input qerm_pkg::rsp_type pinned_rsp = '0);
      bit                has_rsp;
      qerm_pkg::rsp_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_meter(beat, has_rsp, res);
      if (has_rsp) speed_expect_q.push_back(pinned ? pinned_rsp : res);
      beats_sent++;
      if (beat.func == TICK) ticks_sent++;
   endtask

   // Hold off the sender until every result is in and the block has gone quiet.
   task automatic drain_meter();
      req_valid <= 1'b0;
      while (speed_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input logic [qerm_pkg::SPEED_W-1:0] value);
      drain_meter();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      scale_shadow = value;
   endtask

   // Mostly clean Gray-code travel with tick bursts, plus repeats and jumps as noise.
   task automatic run_random(input int unsigned n_beats);
      int unsigned       goal;
      int unsigned       burst;
      int                pick;
      bit                spin_cw;
      qerm_pkg::req_type beat;
      goal    = beats_sent + n_beats;
      spin_cw = 1'($urandom_range(0, 1));
      while (beats_sent < goal) begin
         pick      = $urandom_range(0, 99);
         beat.func = ENC;
         beat.pins = last_pins;
         if (pick < 28) begin
            burst = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                 : $urandom_range(1, 6);
            beat.func = TICK;
            repeat (burst) begin
               beat.pins = PIN_W'($urandom_range(0, 3));
               send_beat(beat);
            end
         end else begin
            if (pick < 85) begin
               if ($urandom_range(0, 9) == 0) spin_cw = !spin_cw;
               beat.pins = spin_cw ? cw_next(last_pins) : ccw_next(last_pins);
            end else if (pick >= 93) begin
               beat.pins = PIN_W'($urandom_range(0, 3));
            end
            send_beat(beat);
         end
      end
   endtask

   // Check each result beat against the oldest expectation, then pick the next stall.
   always @(posedge clock) begin : watch_rsp
      qerm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (speed_expect_q.size() == 0) begin
            note_fault("result with nothing expected", '0, rsp_data);
         end else begin
            want = speed_expect_q.pop_front();
            if (rsp_data.direction !== want.direction)
               note_fault("direction mismatch", want, rsp_data);
            if (rsp_data.speed !== want.speed)
               note_fault("speed mismatch", want, rsp_data);
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Main sequence: reset, directed plan, then random phases at several scales.
   initial begin : run_sequence
      logic [qerm_pkg::SPEED_W-1:0] scale_plan [6];
      qerm_pkg::req_type            beat;
      int                           r;
      int                           seg;
      scale_plan[0] = 16'hFFFF;
      scale_plan[1] = 16'd0;
      scale_plan[2] = 16'd1;
      scale_plan[3] = SPD_W'($urandom_range(2, 65534));
      scale_plan[4] = qerm_pkg::RPM_SCALE_RESET;
      scale_plan[5] = SPD_W'($urandom_range(2, 65534));
      clear_meter_shadow();
      send_idle_pct = 15;
      recv_idle_pct = 87;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed plan under the reset scale.
      for (r = 0; r < $size(plan); r++) begin
         beat.func = plan[r].func;
         beat.pins = plan[r].pins;
         repeat (plan[r].count) send_beat(beat, plan[r].pinned, plan[r].want);
      end

      // Random phases: the stall mix flips after two phases, then both sides run free.
      for (seg = 0; seg < 6; seg++) begin
         write_scale(scale_plan[seg]);
         case (seg / 2)
            0: begin
               send_idle_pct = 15;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 15;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         run_random(162);
      end

      drain_meter();
      if (speed_expect_q.size() != 0) begin
         mismatches += speed_expect_q.size();
         $display("ERROR %0d results never arrived", speed_expect_q.size());
      end
      $display("Run covered %0d request beats (%0d timer ticks) and %0d checked results,",
               beats_sent, ticks_sent, results_seen);
      $display("with the scale at zero, one, full, reset and random values and three stall mixes.");
      if (mismatches == 0)
         $display("** quadrature_encoder_rpm_meter: PASSED **");
      else
         $display("** quadrature_encoder_rpm_meter: FAILED **");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin : watchdog
      #(10_000_000);
      $display("ERROR timeout with %0d results outstanding", speed_expect_q.size());
      $display("** quadrature_encoder_rpm_meter: FAILED **");
      $finish;
   end

endmodule

@@ quadrature_encoder_rpm_meter.f @@
hdl/qerm_pkg.sv
hdl/qerm_div.sv
hdl/qerm_dp.sv
hdl/qerm_ctrl.sv
hdl/quadrature_encoder_rpm_meter.sv
verif/tb_top.sv
